>>> design/spq_pkg.sv
// Shared types for the sorted priority process queue.
// No dependencies; imported by spq_ctrl, spq_datapath and the top level.
package spq_pkg;

	// Operation codes
	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} op_t;

	// One queue entry
	typedef struct packed {
		logic [7:0]  id;
		logic [7:0]  pri;
		logic [15:0] rtime;
	} entry_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;    // latch input fields, arm the scan
		logic insert;  // sorted insert of the latched entry
		logic step;    // one rotate/drop step of the remove scan
		logic finish;  // capture result registers
	} spq_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic scan_done;  // every original entry has passed the head
	} spq_stat_t;

endpackage

>>> design/sorted_priority_process_queue.sv
// Top level of the sorted priority process queue: controller plus datapath.
// Depends on spq_pkg, spq_ctrl and spq_datapath.
//
// Usage:
//   Command channel: a request (operation, process_id, priority_req,
//   remaining_time) transfers at a rising edge with start high and busy low.
//   operation OP_INSERT places the entry behind every held entry of equal or
//   lower priority value; a full queue rejects it. OP_REMOVE deletes the first
//   held entry, in queue order, whose remaining time is zero.
//   Result channel: done is high for exactly one cycle while queue_length,
//   insert_rejected, removed_valid and removed_id are valid. The receiver
//   cannot stall; results must be taken in that cycle.
//   Sequence: an insert writes the entry and captures its result in the
//   insert state. A remove rotates the N held entries through the head
//   cell one per cycle, then captures its result once all have passed.
//   busy falls in the cycle the result shows, so the next request can
//   transfer on the edge that ends the result cycle.
//   Reset (arst_n low) empties the queue and clears busy and done; entry
//   storage is not cleared, empty cells are never read.
module sorted_priority_process_queue import spq_pkg::*; #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        operation,
	input  logic [7:0]  process_id,
	input  logic [7:0]  priority_req,
	input  logic [15:0] remaining_time,
	output logic        done,
	output logic [4:0]  queue_length,
	output logic        insert_rejected,
	output logic        removed_valid,
	output logic [7:0]  removed_id
);

	spq_cmd_t  cmd;
	spq_stat_t stat;
	op_t       op;

	assign op = op_t'(operation);

	// Sequencer: accepts requests, walks insert or remove scan
	spq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// Entry cells and result registers
	spq_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.op              (op),
		.process_id      (process_id),
		.priority_req    (priority_req),
		.remaining_time  (remaining_time),
		.stat            (stat),
		.queue_length    (queue_length),
		.insert_rejected (insert_rejected),
		.removed_valid   (removed_valid),
		.removed_id      (removed_id)
	);

	// A result always closes a busy period
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a pending request");

	// Reject and remove flags belong to different operations
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(insert_rejected && removed_valid))
		else $error("reject and remove flagged together");

	// No id reported without a removal
	a_id_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !removed_valid) |-> (removed_id == 8'd0))
		else $error("removed_id set without removal");

	// done is a single-cycle strobe
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

endmodule

>>> design/spq_ctrl.sv
// Sequencer for the sorted priority process queue.
// Depends on spq_pkg (op_t, spq_cmd_t, spq_stat_t).
module spq_ctrl import spq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  op_t       op,
	input  spq_stat_t stat,
	output spq_cmd_t  cmd,
	output logic      busy,
	output logic      done
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_INSERT,
		ST_SCAN
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   done_q;
	logic   accept;

	assign accept = start && !busy_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.load = accept;
			end
			ST_INSERT: begin
				cmd.insert = 1'b1;
				cmd.finish = 1'b1;
			end
			ST_SCAN: begin
				cmd.step   = !stat.scan_done;
				cmd.finish = stat.scan_done;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						busy_q  <= 1'b1;
						state_q <= (op == OP_REMOVE) ? ST_SCAN : ST_INSERT;
					end
				end
				ST_INSERT: begin
					busy_q  <= 1'b0;
					state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					if (stat.scan_done) begin
						busy_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					busy_q  <= 1'b0;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy = busy_q;
	assign done = done_q;

endmodule

>>> design/spq_datapath.sv
// Entry cells, length counter, remove scan and result registers.
// Depends on spq_pkg (op_t, entry_t, spq_cmd_t, spq_stat_t).
module spq_datapath import spq_pkg::*; #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  spq_cmd_t    cmd,
	input  op_t         op,
	input  logic [7:0]  process_id,
	input  logic [7:0]  priority_req,
	input  logic [15:0] remaining_time,
	output spq_stat_t   stat,
	output logic [4:0]  queue_length,
	output logic        insert_rejected,
	output logic        removed_valid,
	output logic [7:0]  removed_id
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	// Latched request
	op_t         op_q;
	entry_t      new_q;

	// Cells; only those below count_q hold live entries
	entry_t      cell_q [QUEUE_DEPTH];
	entry_t      cell_d [QUEUE_DEPTH];
	logic [CW-1:0] count_q, count_d;

	// Remove scan
	logic [CW-1:0] steps_q;
	logic          found_q;
	logic [7:0]    rid_q;

	logic [QUEUE_DEPTH-1:0] le;
	logic                   full;
	logic                   drop;
	logic [CW+4:0]          len_ext;

	assign full      = (count_q == CW'(QUEUE_DEPTH));
	assign drop      = !found_q && (cell_q[0].rtime == 16'd0);
	assign stat.scan_done = (steps_q == '0);
	assign len_ext   = {5'b0, count_d};

	// Per-cell compare: entry sits at or before the new one
	always_comb begin
		for (int k = 0; k < QUEUE_DEPTH; k++) begin
			le[k] = (CW'(k) < count_q) && (cell_q[k].pri <= new_q.pri);
		end
	end

	always_comb begin
		for (int k = 0; k < QUEUE_DEPTH; k++) begin
			cell_d[k] = cell_q[k];
		end
		count_d = count_q;
		if (cmd.insert && !full) begin
			// first cell past the equal-or-lower run takes the new entry,
			// everything behind it moves one place back
			if (!le[0]) begin
				cell_d[0] = new_q;
			end
			for (int k = 1; k < QUEUE_DEPTH; k++) begin
				if (!le[k]) begin
					cell_d[k] = le[k-1] ? new_q : cell_q[k-1];
				end
			end
			count_d = count_q + 1'b1;
		end else if (cmd.step) begin
			if (drop) begin
				for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
					cell_d[k] = cell_q[k+1];
				end
				count_d = count_q - 1'b1;
			end else begin
				// rotate live entries: head goes to the tail
				for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
					if (CW'(k + 1) < count_q) begin
						cell_d[k] = cell_q[k+1];
					end
				end
				for (int k = 0; k < QUEUE_DEPTH; k++) begin
					if (CW'(k + 1) == count_q) begin
						cell_d[k] = cell_q[0];
					end
				end
			end
		end
	end

	// Cell contents carry no reset
	always_ff @(posedge clk) begin
		for (int k = 0; k < QUEUE_DEPTH; k++) begin
			cell_q[k] <= cell_d[k];
		end
		if (cmd.load) begin
			op_q        <= op;
			new_q.id    <= process_id;
			new_q.pri   <= priority_req;
			new_q.rtime <= remaining_time;
		end
		if (cmd.finish) begin
			queue_length    <= len_ext[4:0];
			insert_rejected <= (op_q == OP_INSERT) && full;
			removed_valid   <= (op_q == OP_REMOVE) && found_q;
			removed_id      <= (op_q == OP_REMOVE) ? rid_q : 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			steps_q <= '0;
			found_q <= 1'b0;
			rid_q   <= '0;
		end else begin
			count_q <= count_d;
			if (cmd.load) begin
				steps_q <= (op == OP_REMOVE) ? count_q : '0;
				found_q <= 1'b0;
				rid_q   <= '0;
			end else if (cmd.step) begin
				steps_q <= steps_q - 1'b1;
				if (drop) begin
					found_q <= 1'b1;
					rid_q   <= cell_q[0].id;
				end
			end
		end
	end

	// Length never runs past the depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("queue count exceeds depth");

	// A scan step removes at most one entry overall
	a_single_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && found_q) |=> (count_q == $past(count_q)))
		else $error("second entry dropped in one remove");

	// Scan count is armed only for a remove
	a_scan_armed: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (op_q == OP_REMOVE))
		else $error("scan step during insert");

endmodule
